// ----- hw/rtl/multichannel_moving_average_unit_assert.svh -----
// Assertion macros shared by the moving average RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef MULTICHANNEL_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define MULTICHANNEL_MOVING_AVERAGE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MMA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mma_pkg.sv -----
// Package for the multichannel moving average unit: widths, defaults, types.
// Depends on nothing; used by the interfaces, the top, the lane and the merging stage.
`timescale 1ns / 1ps

package mma_pkg;

    localparam int LANES       = 4;
    localparam int CHAN_ID_W   = 2;
    localparam int SAMPLE_W    = 8;
    localparam int MEAN_W      = 8;
    localparam int SUM_W       = 16;
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam int CHANNELS_DEF = 4;
    localparam int WINDOW_DEF   = 8;

    typedef logic [LANES-1:0][CHAN_ID_W-1:0] t_chan_ids;
    typedef logic [LANES-1:0][SAMPLE_W-1:0]  t_samples;
    typedef logic [LANES-1:0][SUM_W-1:0]     t_sums;

    // Sequencer controls toward the lanes.
    typedef struct packed {
        logic wr_en;
        logic acc_clr;
        logic rd_en;
    } t_lane_ctrl;

    // Sequencer controls toward the merging stage.
    typedef struct packed {
        logic emit;
    } t_div_ctrl;

endpackage

// ----- hw/rtl/mma_scan_if.sv -----
// Scan channel: four channel ids and four samples with valid/ready.
// Depends on mma_pkg.
`timescale 1ns / 1ps

interface mma_scan_if;
    logic                          valid;
    logic                          ready;
    logic [mma_pkg::CHAN_ID_W-1:0] chan_id_0;
    logic [mma_pkg::CHAN_ID_W-1:0] chan_id_1;
    logic [mma_pkg::CHAN_ID_W-1:0] chan_id_2;
    logic [mma_pkg::CHAN_ID_W-1:0] chan_id_3;
    logic [mma_pkg::SAMPLE_W-1:0]  sample_0;
    logic [mma_pkg::SAMPLE_W-1:0]  sample_1;
    logic [mma_pkg::SAMPLE_W-1:0]  sample_2;
    logic [mma_pkg::SAMPLE_W-1:0]  sample_3;

    modport source (output valid, chan_id_0, chan_id_1, chan_id_2, chan_id_3,
                    sample_0, sample_1, sample_2, sample_3, input ready);
    modport sink   (input valid, chan_id_0, chan_id_1, chan_id_2, chan_id_3,
                    sample_0, sample_1, sample_2, sample_3, output ready);
endinterface

// ----- hw/rtl/mma_mean_if.sv -----
// Result channel: four held channel means with valid/ready.
// Depends on mma_pkg.
`timescale 1ns / 1ps

interface mma_mean_if;
    logic                       valid;
    logic                       ready;
    logic [mma_pkg::MEAN_W-1:0] mean_0;
    logic [mma_pkg::MEAN_W-1:0] mean_1;
    logic [mma_pkg::MEAN_W-1:0] mean_2;
    logic [mma_pkg::MEAN_W-1:0] mean_3;

    modport source (output valid, mean_0, mean_1, mean_2, mean_3, input ready);
    modport sink   (input valid, mean_0, mean_1, mean_2, mean_3, output ready);
endinterface

// ----- hw/rtl/multichannel_moving_average_unit.sv -----
// An accepted scan passes the ring sweep (S_SUM), the drain (S_DRAIN) and the hand-off
// (S_OUT) before its result is valid; while results are taken, the per-lane ring sweep
// (one RAM read per cycle), the drain and the hand-off set the scan rate.
// A new scan is taken while the previous result waits in the output register.
// Reset (synchronous, active low) clears the sequencer, the write position,
// the output valid and the ring valid bits, so every ring entry reads as zero.
`timescale 1ns / 1ps
`include "multichannel_moving_average_unit_assert.svh"

module multichannel_moving_average_unit #(
    parameter int CHANNELS = mma_pkg::CHANNELS_DEF,
    parameter int WINDOW   = mma_pkg::WINDOW_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mma_scan_if.sink   i_scan,
    mma_mean_if.source o_mean
);

    localparam int AW = $clog2(WINDOW);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_OUT   = 3'd3;

    logic [2:0]                      r_state, n_state;
    logic [AW-1:0]                   r_cnt, n_cnt;
    logic [AW-1:0]                   r_pos, n_pos;
    logic                            w_accept;
    logic                            w_out_free;
    mma_pkg::t_chan_ids              w_ids;
    mma_pkg::t_samples               w_smp;
    mma_pkg::t_sums                  w_sums;
    mma_pkg::t_lane_ctrl             w_lane_ctrl;
    mma_pkg::t_div_ctrl              w_div_ctrl;

    assign i_scan.ready = (r_state == S_IDLE);
    assign w_accept     = i_scan.valid && i_scan.ready;

    assign w_ids = {i_scan.chan_id_3, i_scan.chan_id_2, i_scan.chan_id_1, i_scan.chan_id_0};
    assign w_smp = {i_scan.sample_3, i_scan.sample_2, i_scan.sample_1, i_scan.sample_0};

    // Sequence: write, sweep the rings, drain the read, hand off
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SUM;
                    n_cnt   = '0;
                    n_pos   = (r_pos == AW'(WINDOW - 1)) ? '0 : r_pos + AW'(1);
                end
            end
            S_SUM: begin
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == AW'(WINDOW - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
        end
    end

    // Lane and merge controls
    assign w_lane_ctrl.wr_en   = w_accept;
    assign w_lane_ctrl.acc_clr = w_accept;
    assign w_lane_ctrl.rd_en   = (r_state == S_SUM);

    assign w_div_ctrl.emit = (r_state == S_OUT) && w_out_free;

    // One lane per channel
    for (genvar c = 0; c < mma_pkg::LANES; c++) begin : g_lane
        if (c < CHANNELS) begin : g_on
            mma_lane #(
                .WINDOW  (WINDOW),
                .LANE_ID (c)
            ) u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_lane_ctrl),
                .i_pos      (r_pos),
                .i_raddr    (r_cnt),
                .i_chan_ids (w_ids),
                .i_samples  (w_smp),
                .o_sum      (w_sums[c])
            );
        end else begin : g_off
            assign w_sums[c] = '0;
        end
    end

    mma_merge #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_div_ctrl),
        .i_sums     (w_sums),
        .o_out_free (w_out_free),
        .o_mean     (o_mean)
    );

    `MMA_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept,
        r_state == S_SUM, "accepted scan did not start the ring sweep")
    `MMA_ASSERT_NEXT(a_pos_advance, i_clk, i_rst_n, w_accept,
        r_pos == (($past(r_pos) == AW'(WINDOW - 1)) ? '0 : $past(r_pos) + AW'(1)),
        "write position did not advance by one")
    `MMA_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, w_div_ctrl.emit,
        o_mean.valid && r_state == S_IDLE, "result not presented after hand-off")
    `MMA_ASSERT_NOW(a_busy_no_ready, i_clk, i_rst_n, r_state != S_IDLE,
        !i_scan.ready, "scan accepted while a transaction is in flight")

endmodule

// ----- hw/rtl/mma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module mma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/mma_lane.sv -----
// One channel lane: sample ring in RAM, per-entry valid bits, window summer.
// Depends on mma_pkg, mma_ram and the assertion header.
`timescale 1ns / 1ps
`include "multichannel_moving_average_unit_assert.svh"

module mma_lane #(
    parameter int WINDOW  = mma_pkg::WINDOW_DEF,
    parameter int LANE_ID = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mma_pkg::t_lane_ctrl       i_ctrl,
    input  logic [$clog2(WINDOW)-1:0] i_pos,
    input  logic [$clog2(WINDOW)-1:0] i_raddr,
    input  mma_pkg::t_chan_ids        i_chan_ids,
    input  mma_pkg::t_samples         i_samples,
    output logic [mma_pkg::SUM_W-1:0] o_sum
);

    logic                         w_hit;
    logic [mma_pkg::SAMPLE_W-1:0] w_wdata;
    logic [mma_pkg::SAMPLE_W-1:0] w_rdata;
    logic [WINDOW-1:0]            r_valid;
    logic                         r_rd_vld;
    logic                         r_ent_vld;
    logic [mma_pkg::SUM_W-1:0]    r_sum;

    // Pick this channel's sample; a later sample of the scan wins
    always_comb begin
        w_hit   = 1'b0;
        w_wdata = '0;
        for (int k = 0; k < mma_pkg::LANES; k++) begin
            if (i_chan_ids[k] == mma_pkg::CHAN_ID_W'(LANE_ID)) begin
                w_hit   = 1'b1;
                w_wdata = i_samples[k];
            end
        end
    end

    mma_ram #(
        .WIDTH (mma_pkg::SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.wr_en && w_hit),
        .i_waddr (i_pos),
        .i_wdata (w_wdata),
        .i_re    (i_ctrl.rd_en),
        .i_raddr (i_raddr),
        .o_rdata (w_rdata)
    );

    // Mark written entries; unwritten ones read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_ctrl.rd_en;
            if (i_ctrl.wr_en && w_hit) begin
                r_valid[i_pos] <= 1'b1;
            end
        end
    end

    // Track validity alongside the registered read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_ent_vld <= r_valid[i_raddr];
        end
    end

    // Accumulate the window, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_clr) begin
            r_sum <= '0;
        end else if (r_rd_vld && r_ent_vld) begin
            r_sum <= r_sum + mma_pkg::SUM_W'(w_rdata);
        end
    end

    assign o_sum = r_sum;

    `MMA_ASSERT_NOW(a_sum_bound, i_clk, i_rst_n, r_rd_vld && !i_ctrl.acc_clr,
        r_sum <= mma_pkg::SUM_W'(WINDOW * 255), "lane sum above window bound")
    `MMA_ASSERT_NEXT(a_write_marks, i_clk, i_rst_n, i_ctrl.wr_en && w_hit,
        r_valid[$past(i_pos)], "written ring entry not marked valid")

endmodule

// ----- hw/rtl/mma_merge.sv -----
// Merging stage: divides every lane sum by the window, registers the result.
// Depends on mma_pkg and mma_mean_if.
`timescale 1ns / 1ps

module mma_merge #(
    parameter int CHANNELS = mma_pkg::CHANNELS_DEF,
    parameter int WINDOW   = mma_pkg::WINDOW_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mma_pkg::t_div_ctrl i_ctrl,
    input  mma_pkg::t_sums     i_sums,
    output logic               o_out_free,
    mma_mean_if.source         o_mean
);

    // Rounded-up reciprocal of the window; exact floor for every 16-bit sum
    localparam int RECIP_SH = mma_pkg::SUM_W + $clog2(WINDOW);
    localparam int RECIP_L  = ((1 << RECIP_SH) + WINDOW - 1) / WINDOW;
    localparam logic [mma_pkg::RECIP_W-1:0] RECIP = mma_pkg::RECIP_W'(RECIP_L);

    logic [mma_pkg::MEAN_W-1:0] w_quot [mma_pkg::LANES];
    logic [mma_pkg::MEAN_W-1:0] r_mean [mma_pkg::LANES];
    logic                       r_out_valid;

    // Divide by the window with a reciprocal multiply, all lanes side by side
    for (genvar c = 0; c < mma_pkg::LANES; c++) begin : g_div
        if (c < CHANNELS) begin : g_on
            logic [mma_pkg::PROD_W-1:0] w_prod;

            assign w_prod    = mma_pkg::PROD_W'(i_sums[c]) * mma_pkg::PROD_W'(RECIP);
            assign w_quot[c] = mma_pkg::MEAN_W'(w_prod >> RECIP_SH);
        end else begin : g_off
            assign w_quot[c] = '0;
        end
    end

    assign o_out_free = !r_out_valid || o_mean.ready;

    // Output register: hold until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_mean.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            r_mean <= w_quot;
        end
    end

    assign o_mean.valid  = r_out_valid;
    assign o_mean.mean_0 = r_mean[0];
    assign o_mean.mean_1 = r_mean[1];
    assign o_mean.mean_2 = r_mean[2];
    assign o_mean.mean_3 = r_mean[3];

endmodule
